### rtl/core/mm4_pkg.sv
// ============================================================================
// mm4_pkg
// Shared types and constants of the 4x4 fixed-point matrix multiplier.
// ============================================================================

package mm4_pkg;

    // Default number format: signed Q16.16.
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Port widths, fixed by the word format on the channels.
    localparam int IO_W  = 32;
    localparam int IDX_W = 4;

    // Matrix geometry.
    localparam int DIM   = 4;
    localparam int SEL_W = 2;

    // The load at this position starts a multiply and is the last result.
    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

    // Sequencer states.
    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } mm4_state_t;

endpackage : mm4_pkg

### rtl/core/mm4_in_if.sv
// ============================================================================
// mm4_in_if
// Load channel: one element of each operand matrix per word.
// ============================================================================

interface mm4_in_if import mm4_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic        [IDX_W-1:0] elem_index;
    logic signed [IO_W-1:0]  first_elem;
    logic signed [IO_W-1:0]  second_elem;

    modport source
    (
        output valid,
        output elem_index,
        output first_elem,
        output second_elem,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  elem_index,
        input  first_elem,
        input  second_elem,
        output ready
    );

endinterface : mm4_in_if

### rtl/core/mm4_out_if.sv
// ============================================================================
// mm4_out_if
// Result channel: one element of the product matrix per word.
// ============================================================================

interface mm4_out_if import mm4_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic        [IDX_W-1:0] out_index;
    logic signed [IO_W-1:0]  out_value;
    logic                    last_flag;

    modport source
    (
        output valid,
        output out_index,
        output out_value,
        output last_flag,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  out_index,
        input  out_value,
        input  last_flag,
        output ready
    );

endinterface : mm4_out_if

### rtl/core/mm4_ram.sv
// ============================================================================
// mm4_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================

module mm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; the read data holds while disabled.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : mm4_ram

### rtl/core/matrix4x4_multiply.sv
// ============================================================================
// matrix4x4_multiply
// Signed fixed-point 4x4 matrix product with streamed loads and results.
// ============================================================================
//
// Each load word writes one element of the left and of the right matrix at a
// row-major position. The load at position 15 starts the multiply: the block
// then issues one product element per cycle while the result side does not
// stall, 16 in all, during which it takes no load, and the results leave in
// row-major order through the RAM read, product, pair-sum and output
// registers, the sixteenth flagged as last. The stores are split into four
// banks per matrix so that the four operand pairs of one dot product are
// read in the same cycle and fed to four parallel multipliers. A stall on the
// result side freezes the whole result pipeline. Loads may resume while
// earlier results are still draining. Products are summed at full width,
// shifted right arithmetically by FRAC_BITS and saturated to WORD_BITS bits.

module matrix4x4_multiply import mm4_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    mm4_in_if.sink       load,
    mm4_out_if.source    result
);

    localparam int PROD_W = 2 * WORD_BITS;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    // Sequencer.
    mm4_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic                 load_acc;
    logic                 adv;

    // Banked operand stores.
    logic [WORD_BITS-1:0] left_rd  [DIM];
    logic [WORD_BITS-1:0] right_rd [DIM];

    // Result pipeline.
    logic                    v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]        idx1_reg, idx2_reg, idx3_reg;
    logic signed [PROD_W-1:0] prod_reg [DIM];
    logic signed [PROD_W-1:0] prod_next [DIM];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum_full;
    logic signed [SUM_W-1:0]  sum_shift;
    logic signed [WORD_BITS-1:0] sat_val;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_index_reg;
    logic signed [IO_W-1:0]  out_value_reg, out_value_next;
    logic                    out_last_reg;

    // Handshakes: loads only between runs; the pipeline moves when the
    // output register is empty or its word is being taken.
    assign load.ready = (state_reg == ST_IDLE);
    assign load_acc   = load.valid && load.ready;
    assign adv        = !out_valid_reg || result.ready;

    // Left bank k holds column k (addressed by row); right bank k holds
    // row k (addressed by column).
    for (genvar k = 0; k < DIM; k++)
    begin : g_bank
        mm4_ram #(
            .WIDTH (WORD_BITS),
            .DEPTH (DIM)
        ) u_left (
            .clk     (clk),
            .wr_en   (load_acc && (load.elem_index[SEL_W-1:0] == SEL_W'(k))),
            .wr_addr (load.elem_index[IDX_W-1:SEL_W]),
            .wr_data (load.first_elem[WORD_BITS-1:0]),
            .rd_en   (adv),
            .rd_addr (cnt_reg[IDX_W-1:SEL_W]),
            .rd_data (left_rd[k])
        );

        mm4_ram #(
            .WIDTH (WORD_BITS),
            .DEPTH (DIM)
        ) u_right (
            .clk     (clk),
            .wr_en   (load_acc && (load.elem_index[IDX_W-1:SEL_W] == SEL_W'(k))),
            .wr_addr (load.elem_index[SEL_W-1:0]),
            .wr_data (load.second_elem[WORD_BITS-1:0]),
            .rd_en   (adv),
            .rd_addr (cnt_reg[SEL_W-1:0]),
            .rd_data (right_rd[k])
        );
    end

    // State register and issue counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state: a load at the last position starts a run of 16 issues.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_acc && (load.elem_index == LAST_IDX))
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    cnt_next = IDX_W'(cnt_reg + 1'b1);
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Products, pairwise sums, then final sum with shift and saturation.
    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            prod_next[k] = $signed(left_rd[k]) * $signed(right_rd[k]);
        end
        pair_next[0] = PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_next[1] = PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);

        sum_full  = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        sum_shift = sum_full >>> FRAC_BITS;
        if (sum_shift > SAT_MAX)
        begin
            sat_val = SAT_MAX[WORD_BITS-1:0];
        end
        else if (sum_shift < SAT_MIN)
        begin
            sat_val = SAT_MIN[WORD_BITS-1:0];
        end
        else
        begin
            sat_val = sum_shift[WORD_BITS-1:0];
        end
        out_value_next = IO_W'(sat_val);
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= (state_reg == ST_RUN);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx1_reg      <= cnt_reg;
            idx2_reg      <= idx1_reg;
            idx3_reg      <= idx2_reg;
            prod_reg      <= prod_next;
            pair_reg      <= pair_next;
            out_index_reg <= idx3_reg;
            out_value_reg <= out_value_next;
            out_last_reg  <= (idx3_reg == LAST_IDX);
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_index = out_index_reg;
    assign result.out_value = out_value_reg;
    assign result.last_flag = out_last_reg;

    // A load at the last position starts a run from the first element.
    a_run_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        (load_acc && (load.elem_index == LAST_IDX))
            |=> (state_reg == ST_RUN) && (cnt_reg == '0)
    ) else $error("run did not start from the first element");

    // Issues during a run step through the elements one by one.
    a_run_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && adv && (cnt_reg != LAST_IDX))
            |=> (state_reg == ST_RUN) && (cnt_reg == IDX_W'($past(cnt_reg) + 1'b1))
    ) else $error("issue counter skipped or left the run early");

    // A stalled result side freezes the pipeline occupancy.
    a_stall_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({v1_reg, v2_reg, v3_reg, out_valid_reg})
    ) else $error("pipeline moved while the result side stalled");

endmodule : matrix4x4_multiply
